>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define AST_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion that also holds during reset
`define AST_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> design/aas_pkg.sv
// shared constants, types and letter code functions of the adapter alignment scorer
package aas_pkg;

    localparam int MAX_ADAPTER = 128;
    localparam int MAX_READ    = 1024;

    localparam int ADDR_W = $clog2(MAX_ADAPTER);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int POS_W  = $clog2(MAX_READ) + 1;

    localparam int LETTER_W  = 8;
    localparam int QUAL_W    = 8;
    localparam int RSTART_W  = 11;
    localparam int ASTART_W  = 7;
    localparam int ROFS_W    = RSTART_W - 1;
    localparam int AOFS_W    = ASTART_W + 1;
    localparam int MODE_W    = 2;

    localparam int CMP_W = ((POS_W > RSTART_W) ? POS_W : RSTART_W) + 2;

    localparam int SCORE_W = 23;
    localparam int COUNT_W = 8;
    localparam int PEN_W   = 16;
    localparam int CODE_W  = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_QOFS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINM = 1'd1;

    localparam logic [QUAL_W-1:0] QOFS_RESET = 8'd33;

    localparam logic signed [PEN_W-1:0]   PEN_SCALE    = 16'sd100;
    localparam logic signed [SCORE_W:0]   MATCH_GAIN   = 24'sd602;
    localparam logic signed [SCORE_W-1:0] REJECT_SCORE = -23'sd1000;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX    = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN    = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic [CODE_W-1:0] NO_BASE = 8'hFF;

    typedef struct packed {
        logic                    valid;
        logic                    clear;
        logic                    pair;
        logic                    last;
        logic [CODE_W-1:0]       rcode;
        logic signed [PEN_W-1:0] pen;
    } t_s1;

    function automatic logic [CODE_W-1:0] read_code(input logic [LETTER_W-1:0] c);
        logic [CODE_W-1:0] r;
        case (c) inside
            8'h41, 8'h61: r = 8'd0;
            8'h43, 8'h63: r = 8'd1;
            8'h47, 8'h67: r = 8'd2;
            8'h54, 8'h74: r = 8'd3;
            default:      r = NO_BASE;
        endcase
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] adapter_code(input logic [LETTER_W-1:0] c);
        logic [CODE_W-1:0] r;
        case (c) inside
            8'h41, 8'h61: r = 8'd3;
            8'h43, 8'h63: r = 8'd2;
            8'h47, 8'h67: r = 8'd1;
            8'h54, 8'h74: r = 8'd0;
            default:      r = NO_BASE;
        endcase
        return r;
    endfunction

endpackage

>>> design/aas_ram.sv
// generic simple dual port ram with registered read
module aas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/adapter_alignment_scorer.sv
// adapter alignment scorer top level: adapter store, window control and score accumulator
//
//  channel   dir  handshake             payload
//  s         in   tvalid/tready         tdata letter/quality/read_start/adapter_start,
//                                       tuser mode, tlast last
//  m         out  tvalid/tready         tdata score/match_count, tuser rejected
//  cfg       in   we                    idx, data
//
//  one beat per cycle unless stalled; a final read beat passes the stage one register, then the result register
//  stage one issues the adapter ram read, stage two compares and accumulates
//  the input stalls only when a final read beat reaches stage two while a result still waits
//  adapter store and result data have no reset, control and accumulators clear on a synchronous reset
module adapter_alignment_scorer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // letter, quality, read_start, adapter_start, zero fill
    input  logic [aas_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // mode
    input  logic [aas_pkg::MODE_W-1:0]       i_s_tuser,
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // score, match_count, zero fill
    output logic [aas_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // rejected
    output logic                             o_m_tuser,
    input  logic                             i_cfg_we,
    input  logic [aas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [aas_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = aas_pkg::ADDR_W;
    localparam int LW = aas_pkg::LEN_W;
    localparam int PW = aas_pkg::POS_W;
    localparam int CW = aas_pkg::CMP_W;
    localparam int SW = aas_pkg::SCORE_W;
    localparam int NW = aas_pkg::COUNT_W;

    logic [aas_pkg::QUAL_W-1:0]   r_qofs;
    logic [aas_pkg::COUNT_W-1:0]  r_minm;
    logic [LW-1:0]                r_adapter_length, n_adapter_length;
    logic [LW-1:0]                r_load_index, n_load_index;
    logic [PW-1:0]                r_read_position, n_read_position;
    logic [aas_pkg::ROFS_W-1:0]   r_read_offset, n_read_offset;
    logic [aas_pkg::AOFS_W-1:0]   r_adapter_offset, n_adapter_offset;
    logic signed [SW-1:0]         r_score_sum, n_score_sum;
    logic [NW-1:0]                r_matches, n_matches;
    aas_pkg::t_s1                 r_s1, n_s1;
    logic                         r_out_valid, n_out_valid;
    logic signed [SW-1:0]         r_out_score, n_out_score;
    logic [NW-1:0]                r_out_matches, n_out_matches;
    logic                         r_out_rej, n_out_rej;

    logic                              w_acc, w_stall, w_fire;
    logic [aas_pkg::MODE_W-1:0]        w_mode;
    logic [aas_pkg::LETTER_W-1:0]      w_letter;
    logic [aas_pkg::QUAL_W-1:0]        w_quality;
    logic [aas_pkg::RSTART_W-1:0]      w_rstart;
    logic [aas_pkg::ASTART_W-1:0]      w_astart;
    logic [CW-1:0]                     w_idx, w_lim, w_ai;
    logic                              w_in_range, w_pair;
    logic signed [aas_pkg::QUAL_W:0]   w_q;
    logic signed [aas_pkg::PEN_W-1:0]  w_pen;
    logic                              w_ram_we, w_ram_re;
    logic [aas_pkg::LETTER_W-1:0]      w_ram_rdata;
    logic                              w_match;
    logic signed [SW:0]                w_step, w_sum_x;
    logic signed [SW-1:0]              w_sum_sat;
    logic [NW-1:0]                     w_cnt;

    assign w_letter  = i_s_tdata[7:0];
    assign w_quality = i_s_tdata[15:8];
    assign w_rstart  = i_s_tdata[26:16];
    assign w_astart  = i_s_tdata[33:27];
    assign w_mode    = i_s_tuser;

    assign w_stall    = r_s1.valid && r_s1.last && r_out_valid && !i_m_tready;
    assign o_s_tready = !w_stall;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_fire     = r_s1.valid && !w_stall;

    // alignment window of the current read position
    always_comb begin
        w_in_range = (r_read_position < PW'(aas_pkg::MAX_READ))
                  && (CW'(r_read_position) >= CW'(r_read_offset));
        w_idx  = CW'(r_read_position) - CW'(r_read_offset);
        w_lim  = w_idx + CW'(r_adapter_offset);
        w_pair = w_in_range && (w_lim < CW'(r_adapter_length));
        w_ai   = CW'(r_adapter_length) - w_lim - CW'(1);
        w_q    = $signed({1'b0, w_quality}) - $signed({1'b0, r_qofs});
        w_pen  = aas_pkg::PEN_W'(aas_pkg::PEN_W'(w_q) * aas_pkg::PEN_SCALE);
    end

    // front stage: control state and ram access
    always_comb begin
        n_adapter_length = r_adapter_length;
        n_load_index     = r_load_index;
        n_read_position  = r_read_position;
        n_read_offset    = r_read_offset;
        n_adapter_offset = r_adapter_offset;
        w_ram_we         = 1'b0;
        w_ram_re         = 1'b0;
        n_s1             = '0;
        n_s1.rcode       = aas_pkg::read_code(w_letter);
        n_s1.pen         = w_pen;
        if (w_acc) begin
            unique case (w_mode)
                aas_pkg::MODE_LOAD: begin
                    if (r_load_index < LW'(aas_pkg::MAX_ADAPTER)) begin
                        w_ram_we     = 1'b1;
                        n_load_index = r_load_index + LW'(1);
                    end
                    if (i_s_tlast) begin
                        n_adapter_length = n_load_index;
                        n_load_index     = '0;
                    end
                end
                aas_pkg::MODE_START: begin
                    if (&w_rstart) begin
                        n_read_offset    = '0;
                        n_adapter_offset = {1'b0, w_astart} + aas_pkg::AOFS_W'(1);
                    end else if (w_rstart[aas_pkg::RSTART_W-1]) begin
                        n_read_offset    = '0;
                        n_adapter_offset = {1'b0, w_astart};
                    end else begin
                        n_read_offset    = w_rstart[aas_pkg::ROFS_W-1:0];
                        n_adapter_offset = {1'b0, w_astart};
                    end
                    n_read_position = '0;
                    n_s1.valid      = 1'b1;
                    n_s1.clear      = 1'b1;
                end
                aas_pkg::MODE_READ: begin
                    w_ram_re   = w_pair;
                    n_s1.valid = 1'b1;
                    n_s1.pair  = w_pair;
                    n_s1.last  = i_s_tlast;
                    if (i_s_tlast) begin
                        n_read_position = '0;
                    end else if (r_read_position < PW'(aas_pkg::MAX_READ)) begin
                        n_read_position = r_read_position + PW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    aas_ram #(
        .WIDTH (aas_pkg::LETTER_W),
        .DEPTH (aas_pkg::MAX_ADAPTER)
    ) u_adapter_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_load_index[AW-1:0]),
        .i_wdata (w_letter),
        .i_re    (w_ram_re),
        .i_raddr (w_ai[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // back stage: compare, accumulate, result
    always_comb begin
        w_match   = r_s1.rcode == aas_pkg::adapter_code(w_ram_rdata);
        w_step    = w_match ? aas_pkg::MATCH_GAIN : -(SW+1)'(r_s1.pen);
        w_sum_x   = (SW+1)'(r_score_sum) + w_step;
        if (w_sum_x[SW] != w_sum_x[SW-1]) begin
            w_sum_sat = w_sum_x[SW] ? aas_pkg::SCORE_MIN : aas_pkg::SCORE_MAX;
        end else begin
            w_sum_sat = w_sum_x[SW-1:0];
        end

        n_score_sum = r_score_sum;
        n_matches   = r_matches;
        if (r_s1.pair) begin
            n_score_sum = w_sum_sat;
            if (w_match && (r_matches != {NW{1'b1}})) begin
                n_matches = r_matches + NW'(1);
            end
        end
        w_cnt = n_matches;

        n_out_score   = r_out_score;
        n_out_matches = r_out_matches;
        n_out_rej     = r_out_rej;
        n_out_valid   = r_out_valid && !i_m_tready;
        if (w_fire && r_s1.last) begin
            n_out_valid   = 1'b1;
            n_out_rej     = w_cnt < r_minm;
            n_out_score   = (w_cnt < r_minm) ? aas_pkg::REJECT_SCORE : n_score_sum;
            n_out_matches = w_cnt;
        end
        if (!w_fire) begin
            n_score_sum = r_score_sum;
            n_matches   = r_matches;
        end else if (r_s1.clear || r_s1.last) begin
            n_score_sum = '0;
            n_matches   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qofs           <= aas_pkg::QOFS_RESET;
            r_minm           <= '0;
            r_adapter_length <= '0;
            r_load_index     <= '0;
            r_read_position  <= '0;
            r_read_offset    <= '0;
            r_adapter_offset <= '0;
            r_score_sum      <= '0;
            r_matches        <= '0;
            r_s1             <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    aas_pkg::CFG_QOFS: r_qofs <= i_cfg_data;
                    aas_pkg::CFG_MINM: r_minm <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_adapter_length <= n_adapter_length;
            r_load_index     <= n_load_index;
            r_read_position  <= n_read_position;
            r_read_offset    <= n_read_offset;
            r_adapter_offset <= n_adapter_offset;
            r_score_sum      <= n_score_sum;
            r_matches        <= n_matches;
            if (!w_stall) begin
                r_s1 <= n_s1;
            end
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_score   <= n_out_score;
        r_out_matches <= n_out_matches;
        r_out_rej     <= n_out_rej;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(aas_pkg::M_TDATA_W - SW - NW){1'b0}}, r_out_matches, r_out_score};
    assign o_m_tuser  = r_out_rej;

endmodule

>>> design/aas_chk.sv
// port level checker for the adapter alignment scorer, bound to the top level
`include "assert_macros.svh"

module aas_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [aas_pkg::MODE_W-1:0]       i_s_tuser,
    input logic                             i_s_tlast,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [aas_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input logic                             o_m_tuser
);

    logic                           w_m_hold;
    logic [aas_pkg::M_TDATA_W:0]    w_m_beat;
    logic                           w_rej_ok;
    logic                           w_last_read;

    assign w_m_hold    = o_m_tvalid && !i_m_tready;
    assign w_m_beat    = {o_m_tuser, o_m_tdata};
    assign w_rej_ok    = o_m_tdata[aas_pkg::SCORE_W-1:0] == aas_pkg::REJECT_SCORE;
    assign w_last_read = i_s_tvalid && o_s_tready && i_s_tlast
                      && (i_s_tuser == aas_pkg::MODE_READ);

    // held result stays put
    `AST_CLK(a_out_hold, i_clk, i_rst_n, w_m_hold |=> o_m_tvalid && $stable(w_m_beat))

    // a rejected result carries the reject score
    `AST_CLK(a_rej_score, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> w_rej_ok)

    // reset empties the result register
    `AST_ANY(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid)

    // a new result follows a final read beat that passed through stage one
    `AST_CLK(a_out_cause, i_clk, i_rst_n, $rose(o_m_tvalid) |-> $past(w_last_read, 2))

endmodule

bind adapter_alignment_scorer aas_chk u_aas_chk (.*);
